FILE: rtl/core/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/rbs_pkg.sv
// shared types and constants of the ray box slab test
package rbs_pkg;

  localparam int DIVIDEND_W = 52;
  localparam int DIVISOR_W  = 36;
  localparam int QUOT_W     = 32;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z     = 3'd2;
  localparam logic [2:0] REG_DIR_X        = 3'd3;
  localparam logic [2:0] REG_DIR_Y        = 3'd4;
  localparam logic [2:0] REG_DIR_Z        = 3'd5;
  localparam logic [2:0] REG_PARALLEL_EPS = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_CHECK,
    ST_DIV1,
    ST_WAIT1,
    ST_DIV2,
    ST_WAIT2,
    ST_UPDATE,
    ST_REJCHK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              overflow;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/core/rbs_intf.sv
// handshake interfaces of the slab, result and configuration channels
interface slab_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [17:0] axis_x;
  logic signed [17:0] axis_y;
  logic signed [17:0] axis_z;
  logic [30:0]        half_extent;
  logic               last_slab;

  modport source (output valid, center_x, center_y, center_z, axis_x, axis_y, axis_z,
                  half_extent, last_slab, input ready);
  modport sink (input valid, center_x, center_y, center_z, axis_x, axis_y, axis_z,
                half_extent, last_slab, output ready);
endinterface

interface hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

interface cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/rbs_div.sv
// iterative restoring divider, one quotient bit per cycle, overflow flagged early
module rbs_div (
  input  logic              clk,
  input  logic              rst,
  input  rbs_pkg::div_req_t req,
  output rbs_pkg::div_rsp_t rsp
);
  import rbs_pkg::*;

  logic                 busy;
  logic                 done;
  logic                 ovf;
  logic [4:0]           cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [QUOT_W-1:0]    q_sh;

  logic [DIVISOR_W-1:0] top_ext;
  logic                 top_ge;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   dvs_ext;
  logic                 trial_ge;

  // quotient fits in QUOT_W bits only when the upper dividend part is below the divisor
  assign top_ext  = DIVISOR_W'(req.dividend[DIVIDEND_W-1:QUOT_W]);
  assign top_ge   = top_ext >= req.divisor;
  assign trial    = {rem, q_sh[QUOT_W-1]};
  assign dvs_ext  = {1'b0, dvs};
  assign trial_ge = trial >= dvs_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvs <= req.divisor;
        if (top_ge) begin
          ovf  <= 1'b1;
          done <= 1'b1;
        end else begin
          ovf  <= 1'b0;
          rem  <= top_ext;
          q_sh <= req.dividend[QUOT_W-1:0];
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (trial_ge) begin
          rem <= DIVISOR_W'(trial - dvs_ext);
        end else begin
          rem <= trial[DIVISOR_W-1:0];
        end
        q_sh <= {q_sh[QUOT_W-2:0], trial_ge};
        cnt  <= cnt + 5'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.overflow = ovf;
  assign rsp.quotient = q_sh;

endmodule

FILE: rtl/core/ray_box_slab_test.sv
// top level of the ray against oriented box slab test
`include "assert_macros.svh"

// Slab test of one ray, held in the configuration registers, against oriented boxes in
// signed Q16.16. Each slab transfer brings the box centre, one unit axis and the half
// extent along it; the slab flagged last_slab also yields one hit transfer (1 = the ray
// meets the box) and clears the entry/exit interval for the next box. One slab is worked
// on at a time and slab.ready is low meanwhile. A slab that needs the divide is taken,
// then runs the two dot products on the shared 18x33 multiplier (pipelined through an
// accumulator), a check picks the divide or the parallel test, then two divisions run
// on the shared one-bit-per-cycle divider (a saturating quotient is flagged early
// instead), and last the interval is narrowed and checked for a reject. A slab parallel
// to the ray skips the divisions and the narrowing, and a slab of a box already rejected
// skips the multiplier, the divisions and the narrowing.
// The hit result waits in an output register, so the next slab is taken while it waits;
// configuration writes are taken at any time but belong to idle periods.
module ray_box_slab_test (
  input logic   clk,
  input logic   rst,
  slab_if.sink  slab,
  hit_if.source res,
  cfg_if.sink   cfg
);
  import rbs_pkg::*;

  // ray configuration
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic signed [31:0] dir_x, dir_y, dir_z;
  logic [15:0]        parallel_eps;

  // interval state of the box under test
  logic signed [31:0] enter_param;
  logic signed [31:0] exit_param;
  logic               rejected;
  logic               interval_clear;

  state_t state, state_next;

  // captured slab
  logic signed [32:0] p_x, p_y, p_z;
  logic signed [17:0] ax_r, ay_r, az_r;
  logic [30:0]        h_r;
  logic               last_r;

  // multiply-accumulate path
  logic [2:0]         mcnt;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] prod;
  logic signed [51:0] acc;
  logic signed [35:0] e_r;
  logic signed [35:0] f_r;

  // division path
  logic signed [31:0]   t1, t2;
  logic                 num_neg;
  logic signed [36:0]   num;
  logic [36:0]          num_abs;
  logic [DIVISOR_W-1:0] abs_acc;
  logic [DIVISOR_W-1:0] abs_f;
  logic                 slab_div;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // parallel slab test and interval narrowing
  logic signed [36:0] e_ext, h_ext;
  logic               outside;
  logic signed [31:0] t_lo, t_hi;

  // result register
  logic out_valid;
  logic hit_r;
  logic load_result;
  logic slab_ready;

  function automatic logic [DIVISOR_W-1:0] mag36(input logic signed [35:0] v);
    logic [35:0] n;
    n = 36'(-v);
    return v[35] ? n : v;
  endfunction

  // signed saturating result from an unsigned quotient and the sign of the division
  function automatic logic signed [31:0] sat_quot(input logic [QUOT_W-1:0] q,
                                                  input logic ovf, input logic neg);
    logic signed [31:0] r;
    if (ovf) begin
      r = neg ? Q_MIN : Q_MAX;
    end else if (!neg) begin
      r = q[QUOT_W-1] ? Q_MAX : $signed(q);
    end else if (q[QUOT_W-1] && (q[QUOT_W-2:0] != '0)) begin
      r = Q_MIN;
    end else begin
      r = $signed(32'(-q));
    end
    return r;
  endfunction

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      dir_x        <= 32'sd65536;
      dir_y        <= '0;
      dir_z        <= '0;
      parallel_eps <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ORIGIN_X:     origin_x <= cfg.data;
        REG_ORIGIN_Y:     origin_y <= cfg.data;
        REG_ORIGIN_Z:     origin_z <= cfg.data;
        REG_DIR_X:        dir_x <= cfg.data;
        REG_DIR_Y:        dir_y <= cfg.data;
        REG_DIR_Z:        dir_z <= cfg.data;
        REG_PARALLEL_EPS: parallel_eps <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // multiplier operands: three steps for e, three for f
  always_comb begin
    case (mcnt)
      3'd0: begin mul_a = ax_r; mul_b = p_x; end
      3'd1: begin mul_a = ay_r; mul_b = p_y; end
      3'd2: begin mul_a = az_r; mul_b = p_z; end
      3'd3: begin mul_a = ax_r; mul_b = {dir_x[31], dir_x}; end
      3'd4: begin mul_a = ay_r; mul_b = {dir_y[31], dir_y}; end
      3'd5: begin mul_a = az_r; mul_b = {dir_z[31], dir_z}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // floor to Q16.16 is the arithmetic drop of the low 16 bits
  assign abs_acc  = mag36(acc[51:16]);
  assign abs_f    = mag36(f_r);
  assign slab_div = abs_acc > DIVISOR_W'(parallel_eps);

  // e + h for the first division, e - h for the second
  assign num     = (state == ST_DIV1) ? (37'(e_r) + $signed({6'b0, h_r}))
                                      : (37'(e_r) - $signed({6'b0, h_r}));
  assign num_abs = num[36] ? 37'(-num) : num;

  assign e_ext   = 37'(e_r);
  assign h_ext   = $signed({6'b0, h_r});
  assign outside = (e_ext > h_ext) || (e_ext < -h_ext);

  assign t_lo = (t1 > t2) ? t2 : t1;
  assign t_hi = (t1 > t2) ? t1 : t2;

  assign interval_clear = (enter_param == '0) && (exit_param == Q_MAX) && !rejected;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (slab.valid) state_next = rejected ? ST_FINISH : ST_MAC;
      ST_MAC:    if (mcnt == 3'd6) state_next = ST_CHECK;
      ST_CHECK:  state_next = slab_div ? ST_DIV1 : ST_FINISH;
      ST_DIV1:   state_next = ST_WAIT1;
      ST_WAIT1:  if (div_rsp.done) state_next = ST_DIV2;
      ST_DIV2:   state_next = ST_WAIT2;
      ST_WAIT2:  if (div_rsp.done) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_REJCHK;
      ST_REJCHK: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!last_r || !out_valid || res.ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    slab_ready       = (state == ST_IDLE);
    div_req.start    = (state == ST_DIV1) || (state == ST_DIV2);
    div_req.dividend = {num_abs[35:0], 16'b0};
    div_req.divisor  = abs_f;
    load_result      = (state == ST_FINISH) && last_r && (!out_valid || res.ready);
  end

  assign slab.ready = slab_ready;
  assign res.valid  = out_valid;
  assign res.hit    = hit_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hit register valid: a new result may replace one leaving in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (res.valid && res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      enter_param <= '0;
      exit_param  <= Q_MAX;
      rejected    <= 1'b0;
      mcnt        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (slab.valid) begin
            p_x    <= {slab.center_x[31], slab.center_x} - {origin_x[31], origin_x};
            p_y    <= {slab.center_y[31], slab.center_y} - {origin_y[31], origin_y};
            p_z    <= {slab.center_z[31], slab.center_z} - {origin_z[31], origin_z};
            ax_r   <= slab.axis_x;
            ay_r   <= slab.axis_y;
            az_r   <= slab.axis_z;
            h_r    <= slab.half_extent;
            last_r <= slab.last_slab;
            mcnt   <= '0;
          end
        end
        ST_MAC: begin
          mcnt <= mcnt + 3'd1;
          if (mcnt != 3'd6) prod <= mul_a * mul_b;
          case (mcnt)
            3'd1:    acc <= 52'(prod);
            3'd4: begin
              e_r <= acc[51:16];
              acc <= 52'(prod);
            end
            3'd0:    ;
            default: acc <= acc + 52'(prod);
          endcase
        end
        ST_CHECK: begin
          f_r <= acc[51:16];
          if (!slab_div && outside) rejected <= 1'b1;
        end
        ST_DIV1, ST_DIV2: num_neg <= num[36];
        ST_WAIT1: begin
          if (div_rsp.done) begin
            t1 <= sat_quot(div_rsp.quotient, div_rsp.overflow, num_neg ^ f_r[35]);
          end
        end
        ST_WAIT2: begin
          if (div_rsp.done) begin
            t2 <= sat_quot(div_rsp.quotient, div_rsp.overflow, num_neg ^ f_r[35]);
          end
        end
        ST_UPDATE: begin
          if (t_lo > enter_param) enter_param <= t_lo;
          if (t_hi < exit_param) exit_param <= t_hi;
        end
        ST_REJCHK: begin
          if (enter_param > exit_param) rejected <= 1'b1;
        end
        ST_FINISH: begin
          if (load_result) begin
            hit_r       <= !rejected;
            enter_param <= '0;
            exit_param  <= Q_MAX;
            rejected    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  rbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // interval is cleared right after a result is loaded
  `ASSERT_NEXT(a_clear_after_result, clk, rst, load_result, interval_clear)
  // an open interval while idle never has entry beyond exit
  `ASSERT_IMPL(a_interval_order, clk, rst, (state == ST_IDLE) && !rejected, enter_param <= exit_param)
  // the divider only starts on a slab that is not parallel
  `ASSERT_IMPL(a_div_not_parallel, clk, rst, div_req.start, abs_f > DIVISOR_W'(parallel_eps))
  // divider completion only arrives while waiting for it
  `ASSERT_IMPL(a_done_in_wait, clk, rst, div_rsp.done, (state == ST_WAIT1) || (state == ST_WAIT2))

endmodule

FILE: tb/ray_box_slab_test_tb.sv
// self-checking testbench of the ray against oriented box slab test
module ray_box_slab_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbs_pkg::*;

  // Q16.16 one, and the 45 degree component cos(pi/4) in Q16.16
  localparam longint ONE = 65536;
  localparam longint C45 = 46341;
  // index past the register list, writes to it must be dropped
  localparam logic [2:0] REG_NONE = 3'd7;
  // quiet period, longer than a slab that needs the divide
  localparam int SETTLE_CYCLES = 200;
  // longest wait for outstanding hits before giving up on them
  localparam int RESULT_WAIT_LIMIT = 20000;

  // one slab as it goes over the slab channel
  typedef struct {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [17:0] axis_x;
    logic signed [17:0] axis_y;
    logic signed [17:0] axis_z;
    logic [30:0]        half_extent;
    logic               last_slab;
  } slab_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slab_if slab_ch ();
  hit_if  hit_ch ();
  cfg_if  cfg_ch ();

  ray_box_slab_test dut (
    .clk  (clk),
    .rst  (rst),
    .slab (slab_ch),
    .res  (hit_ch),
    .cfg  (cfg_ch)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the ray registers and of the per-box interval
  // ---------------------------------------------------------------------------
  logic signed [31:0] shadow_origin [3];
  logic signed [31:0] ray_dir    [3];
  logic [15:0]        par_eps;
  logic signed [31:0] t_enter;
  logic signed [31:0] t_exit;
  bit                 box_rejected;

  // hit values still owed by the block, oldest first
  bit expected_hits [$];

  int send_idle_pct = 19;
  int recv_idle_pct = 67;
  int slabs_sent    = 0;
  int mismatches    = 0;
  bit hit_wanted;

  // fresh interval for the next box
  task automatic clear_interval();
    t_enter      = '0;
    t_exit       = Q_MAX;
    box_rejected = 1'b0;
  endtask

  function automatic logic signed [31:0] sat_q16(input longint x);
    if (x > longint'(Q_MAX)) return Q_MAX;
    if (x < longint'(Q_MIN)) return Q_MIN;
    return 32'(x);
  endfunction

  // run one accepted slab through the interval narrowing, and queue the hit
  // value when it closes the box
  task automatic narrow_interval(input slab_t s);
    longint px, py, pz, ax, ay, az, h, e, f, mag, t_a, t_b;
    logic signed [31:0] t_near, t_far;
    if (!box_rejected) begin
      // centre relative to origin is exact in 33 bits
      px = longint'(s.center_x) - longint'(shadow_origin[0]);
      py = longint'(s.center_y) - longint'(shadow_origin[1]);
      pz = longint'(s.center_z) - longint'(shadow_origin[2]);
      ax = longint'(s.axis_x);
      ay = longint'(s.axis_y);
      az = longint'(s.axis_z);
      h  = longint'(s.half_extent);
      // dot products floored back to Q16.16, kept at full width
      e = (ax * px + ay * py + az * pz) >>> 16;
      f = (ax * longint'(ray_dir[0]) + ay * longint'(ray_dir[1]) +
           az * longint'(ray_dir[2])) >>> 16;
      mag = (f < 0) ? -f : f;
      if (mag > longint'(par_eps)) begin
        // integer division truncates toward zero, then clamp to 32 bits
        t_a = ((e + h) * 65536) / f;
        t_b = ((e - h) * 65536) / f;
        t_near = sat_q16(t_a);
        t_far  = sat_q16(t_b);
        if (t_near > t_far) begin
          t_near = sat_q16(t_b);
          t_far  = sat_q16(t_a);
        end
        if (t_near > t_enter) t_enter = t_near;
        if (t_far < t_exit) t_exit = t_far;
        if (t_enter > t_exit) box_rejected = 1'b1;
      end else if (e < -h || e > h) begin
        // parallel slab with the origin outside it
        box_rejected = 1'b1;
      end
    end
    if (s.last_slab) begin
      expected_hits.insert(expected_hits.size(), !box_rejected);
      clear_interval();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure at the falling edge, check at the rising
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    hit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && hit_ch.valid && hit_ch.ready) begin
      if (expected_hits.size() == 0) begin
        $error("hit transfer with nothing expected: hit=%0b", hit_ch.hit);
        mismatches++;
      end else begin
        hit_wanted = expected_hits.pop_front();
        if (hit_ch.hit !== hit_wanted) begin
          $error("field hit: expected %0b, actual %0b", hit_wanted, hit_ch.hit);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one slab transfer, with random sender gaps before it
  task automatic send_slab(input slab_t s);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      slab_ch.valid <= 1'b0;
      @(negedge clk);
    end
    slab_ch.valid       <= 1'b1;
    slab_ch.center_x    <= s.center_x;
    slab_ch.center_y    <= s.center_y;
    slab_ch.center_z    <= s.center_z;
    slab_ch.axis_x      <= s.axis_x;
    slab_ch.axis_y      <= s.axis_y;
    slab_ch.axis_z      <= s.axis_z;
    slab_ch.half_extent <= s.half_extent;
    slab_ch.last_slab   <= s.last_slab;
    do @(posedge clk); while (!slab_ch.ready);
    slabs_sent++;
    narrow_interval(s);
  endtask

  // one register write; only called while the block is quiet
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      REG_ORIGIN_X:     shadow_origin[0] = value;
      REG_ORIGIN_Y:     shadow_origin[1] = value;
      REG_ORIGIN_Z:     shadow_origin[2] = value;
      REG_DIR_X:        ray_dir[0] = value;
      REG_DIR_Y:        ray_dir[1] = value;
      REG_DIR_Z:        ray_dir[2] = value;
      REG_PARALLEL_EPS: par_eps = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // drop valid and hold off until every owed hit has come back or the wait limit runs out
  task automatic wait_for_results();
    int waited;
    waited = 0;
    @(negedge clk);
    slab_ch.valid <= 1'b0;
    while (expected_hits.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_hits.size() != 0) begin
      $error("%0d hit transfers never arrived", expected_hits.size());
      mismatches++;
      expected_hits.delete();
    end
  endtask

  // quiet period: all hits back, then long enough for a slab that has no hit
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new ray; the upper half of the epsilon write is junk the block must drop
  task automatic set_ray(input longint ox, oy, oz, dx, dy, dz, input logic [15:0] eps);
    logic [31:0] junk;
    junk = $urandom;
    settle();
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_ORIGIN_Z, 32'(oz));
    write_reg(REG_DIR_X, 32'(dx));
    write_reg(REG_DIR_Y, 32'(dy));
    write_reg(REG_DIR_Z, 32'(dz));
    write_reg(REG_PARALLEL_EPS, {junk[31:16], eps});
  endtask

  function automatic slab_t make_slab(input longint cx, cy, cz, ax, ay, az, h,
                                      input bit last);
    slab_t s;
    s.center_x    = 32'(cx);
    s.center_y    = 32'(cy);
    s.center_z    = 32'(cz);
    s.axis_x      = 18'(ax);
    s.axis_y      = 18'(ay);
    s.axis_z      = 18'(az);
    s.half_extent = 31'(h);
    s.last_slab   = last;
    return s;
  endfunction

  // well-formed box: orthonormal axes (axis aligned or turned 45 degrees),
  // centre placed near the current ray so that hits and misses both occur
  task automatic send_box_along_ray();
    longint axes [3][3];
    longint row [3];
    longint c [3];
    longint t, off, h;
    int k, i, j, n, pick, nslab;
    foreach (axes[a, b]) axes[a][b] = 0;
    if ($urandom_range(1) == 0) begin
      foreach (axes[a]) axes[a][a] = ONE;
    end else begin
      k = $urandom_range(2);
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      axes[0][i] = C45;
      axes[0][j] = C45;
      axes[1][i] = -C45;
      axes[1][j] = C45;
      axes[2][k] = ONE;
    end
    // shuffle slab order and flip axis signs
    for (n = 2; n > 0; n--) begin
      pick = $urandom_range(n);
      row = axes[n];
      axes[n] = axes[pick];
      axes[pick] = row;
    end
    for (i = 0; i < 3; i++) begin
      if ($urandom_range(1) == 1) begin
        for (j = 0; j < 3; j++) axes[i][j] = -axes[i][j];
      end
    end
    // distance along the ray, sometimes behind the origin
    t = longint'($urandom_range(40 * ONE));
    if ($urandom_range(9) < 2) t = -t;
    foreach (c[d]) begin
      off = ($urandom_range(1) == 1) ? longint'($urandom_range(6 * ONE)) - 3 * ONE : 0;
      c[d] = longint'(shadow_origin[d]) + ((longint'(ray_dir[d]) * t) >>> 16) + off;
    end
    // now and then a fourth slab that repeats the first axis
    nslab = ($urandom_range(9) == 0) ? 4 : 3;
    for (n = 0; n < nslab; n++) begin
      h = longint'($urandom_range(6 * ONE, ONE / 8));
      send_slab(make_slab(c[0], c[1], c[2], axes[n % 3][0], axes[n % 3][1],
                          axes[n % 3][2], h, n == nslab - 1));
    end
  endtask

  // junk box: one to five slabs with every field but last_slab random over its full width
  task automatic send_noise_box();
    slab_t s;
    int n, nslab;
    nslab = $urandom_range(5, 1);
    for (n = 0; n < nslab; n++) begin
      s.center_x    = $urandom;
      s.center_y    = $urandom;
      s.center_z    = $urandom;
      s.axis_x      = 18'($urandom);
      s.axis_y      = 18'($urandom);
      s.axis_z      = 18'($urandom);
      s.half_extent = 31'($urandom);
      s.last_slab   = (n == nslab - 1);
      send_slab(s);
    end
  endtask

  // random ray: mostly near an axis and unit length, sometimes anything
  task automatic random_ray();
    longint o [3];
    longint dv [3];
    int kind, d;
    logic [15:0] eps;
    kind = $urandom_range(9);
    foreach (o[a]) o[a] = longint'($urandom_range(200 * ONE)) - 100 * ONE;
    if (kind < 6) begin
      foreach (dv[a]) dv[a] = ($urandom_range(1) == 1) ?
                              longint'($urandom_range(ONE / 2)) - ONE / 4 : 0;
      d = $urandom_range(2);
      dv[d] = ($urandom_range(1) == 1) ? ONE : -ONE;
    end else if (kind < 8) begin
      foreach (dv[a]) dv[a] = longint'($urandom_range(2 * ONE)) - ONE;
    end else begin
      foreach (o[a]) o[a] = longint'($urandom);
      foreach (dv[a]) dv[a] = longint'($urandom);
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: eps = '0;
      5:             eps = 16'hFFFF;
      default:       eps = 16'($urandom);
    endcase
    set_ray(o[0], o[1], o[2], dv[0], dv[1], dv[2], eps);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // runs on the reset ray: origin 0, direction +x, no parallel band
  task automatic test_directed();
    // box straddling the ray ahead of the origin: hit
    send_slab(make_slab(10 * ONE, 0, 0, ONE, 0, 0, ONE, 0));
    send_slab(make_slab(10 * ONE, 0, 0, 0, ONE, 0, ONE, 0));
    send_slab(make_slab(10 * ONE, 0, 0, 0, 0, ONE, ONE, 1));
    // write past the register list, the ray must be left alone
    settle();
    write_reg(REG_NONE, 32'h0);
    // box wholly behind the origin, later slabs land after the reject
    send_slab(make_slab(-10 * ONE, 0, 0, ONE, 0, 0, ONE, 0));
    send_slab(make_slab(-10 * ONE, 0, 0, 0, ONE, 0, ONE, 0));
    send_slab(make_slab(-10 * ONE, 0, 0, 0, 0, ONE, ONE, 1));
    // parallel slab with the origin off to the side: reject
    send_slab(make_slab(10 * ONE, 5 * ONE, 0, 0, ONE, 0, ONE, 0));
    send_slab(make_slab(10 * ONE, 5 * ONE, 0, ONE, 0, 0, ONE, 0));
    send_slab(make_slab(10 * ONE, 5 * ONE, 0, 0, 0, ONE, ONE, 1));
    // parallel slab with the origin exactly on its face: still inside
    send_slab(make_slab(10 * ONE, -ONE, 0, 0, ONE, 0, ONE, 0));
    send_slab(make_slab(10 * ONE, -ONE, 0, ONE, 0, 0, ONE, 1));
    // single slab box, negative axis, origin inside
    send_slab(make_slab(0, 0, 0, -ONE, 0, 0, 2 * ONE, 1));
    // tiny axis against huge extent: both parameters saturate, then the
    // most negative axis on a parallel slab rejects
    send_slab(make_slab(Q_MAX, 0, 0, 1, 0, 0, 31'h7FFF_FFFF, 0));
    send_slab(make_slab(0, Q_MIN, 0, 0, -131072, 0, 0, 0));
    send_slab(make_slab(Q_MIN, Q_MAX, Q_MIN, -131072, 131071, -131072, 0, 1));
    // zero half extent: interval collapses to one point, still a hit
    send_slab(make_slab(5 * ONE, 0, 0, ONE, 0, 0, 0, 0));
    send_slab(make_slab(5 * ONE, 0, 0, 131071, 0, 0, 0, 0));
    send_slab(make_slab(5 * ONE, 0, 0, 0, 131071, 0, 0, 1));
    // more than three slabs in one box
    send_slab(make_slab(20 * ONE, 0, 0, ONE, 0, 0, 2 * ONE, 0));
    send_slab(make_slab(20 * ONE, 0, 0, 0, ONE, 0, 2 * ONE, 0));
    send_slab(make_slab(20 * ONE, 0, 0, 0, 0, ONE, 2 * ONE, 0));
    send_slab(make_slab(20 * ONE, 0, 0, C45, C45, 0, 3 * ONE, 0));
    send_slab(make_slab(20 * ONE, 0, 0, -C45, C45, 0, 3 * ONE, 1));
    wait_for_results();
  endtask

  // slab with |f| right at the parallel band edge, then just outside it
  task automatic test_parallel_eps();
    int n;
    for (n = 0; n < 2; n++) begin
      // n = 0: |f| equals the band and counts as parallel, origin 5.5 off: miss
      // n = 1: band one lsb smaller, so it divides and the ray goes through
      set_ray(0, 0, 0, ONE, ONE / 2, 0, (n == 0) ? 16'h8000 : 16'h7FFF);
      send_slab(make_slab(10 * ONE, 11 * ONE / 2, 0, 0, ONE, 0, ONE, 0));
      send_slab(make_slab(10 * ONE, 11 * ONE / 2, 0, ONE, 0, 0, ONE, 0));
      send_slab(make_slab(10 * ONE, 11 * ONE / 2, 0, 0, 0, ONE, ONE, 1));
      // same with a negative axis, f = -0.5
      send_slab(make_slab(10 * ONE, 11 * ONE / 2, 0, 0, -ONE, 0, ONE, 0));
      send_slab(make_slab(10 * ONE, 11 * ONE / 2, 0, -ONE, 0, 0, ONE, 1));
    end
    // widest band still leaves a unit direction on the divide path
    set_ray(0, 0, 0, ONE, 0, 0, 16'hFFFF);
    send_slab(make_slab(10 * ONE, 0, 0, ONE, 0, 0, ONE, 0));
    send_slab(make_slab(10 * ONE, 0, 0, 0, ONE, 0, ONE, 1));
    wait_for_results();
  endtask

  // register extremes, each followed by a few boxes
  task automatic test_extreme_rays();
    int r, n;
    for (r = 0; r < 4; r++) begin
      case (r)
        0: set_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 16'hFFFF);
        1: set_ray(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 16'h0000);
        // zero direction: every slab is parallel
        2: set_ray(0, 0, 0, 0, 0, 0, 16'h0000);
        default: set_ray(-ONE, ONE, 0, 1, 1, -1, 16'h0000);
      endcase
      for (n = 0; n < 5; n++) begin
        if (n < 3) send_box_along_ray();
        else send_noise_box();
      end
    end
    wait_for_results();
  endtask

  // random rays with mostly well-formed boxes and some junk in between
  task automatic test_random_boxes(input int n_slabs);
    int stop_at, boxes_left;
    stop_at = slabs_sent + n_slabs;
    boxes_left = 0;
    while (slabs_sent < stop_at) begin
      if (boxes_left == 0) begin
        random_ray();
        boxes_left = $urandom_range(14, 6);
      end
      if ($urandom_range(9) < 8) send_box_along_ray();
      else send_noise_box();
      boxes_left--;
      // now and then let the block run completely dry
      if ($urandom_range(24) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    slab_ch.valid       = 1'b0;
    slab_ch.center_x    = '0;
    slab_ch.center_y    = '0;
    slab_ch.center_z    = '0;
    slab_ch.axis_x      = '0;
    slab_ch.axis_y      = '0;
    slab_ch.axis_z      = '0;
    slab_ch.half_extent = '0;
    slab_ch.last_slab   = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    hit_ch.ready        = 1'b0;

    // shadow registers start at the reset ray: origin 0, direction +x
    foreach (shadow_origin[a]) shadow_origin[a] = '0;
    ray_dir[0] = 32'(ONE);
    ray_dir[1] = '0;
    ray_dir[2] = '0;
    par_eps    = '0;
    clear_interval();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles little, receiver stalls a lot
    send_idle_pct = 19;
    recv_idle_pct = 67;
    test_directed();
    test_parallel_eps();
    test_extreme_rays();
    test_random_boxes(100);

    // the other way round
    send_idle_pct = 67;
    recv_idle_pct = 19;
    test_random_boxes(100);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_boxes(100);

    settle();
    if (mismatches == 0) begin
      $display("[ray_box_slab_test] OK");
    end else begin
      $display("[ray_box_slab_test] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[ray_box_slab_test] ERROR");
    $finish;
  end

endmodule
